[rtl/signed_chat_frame_deframer_unit_defines.svh]
// assertion macros used by the deframer top level
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef SIGNED_CHAT_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SIGNED_CHAT_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define SCFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/scfd_pkg.sv]
// types and constants for the signed chat frame deframer
// no dependencies
`default_nettype none

package scfd_pkg;

    localparam int unsigned POS_W = 9;
    localparam int unsigned LEN_W = POS_W + 1;

    localparam logic [POS_W-1:0] MIN_PAYLOAD = POS_W'(8);
    localparam logic [7:0]       MIN_HEADER  = 8'd8;
    localparam logic [15:0]      MAGIC_RESET = 16'hA455;

    localparam int unsigned FLAG_MULTI_BIT  = 0;
    localparam int unsigned FLAG_SIGNED_BIT = 1;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  content_byte;
        logic        content_valid;
        logic        frame_end;
        logic [2:0]  frame_status;
        logic [31:0] frame_timestamp;
        logic        is_multipart;
        logic [7:0]  part_num;
        logic [7:0]  last_part_num;
        logic        is_signed;
        logic [7:0]  signature_length;
    } t_out_word;

    typedef struct packed {
        logic      has_result;
        t_out_word word;
    } t_result;

endpackage

`default_nettype wire

[rtl/scfd_core.sv]
// frame state and per-byte decode for the deframer
// depends on scfd_pkg
`default_nettype none

module scfd_core
    import scfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire t_in_word   i_word,
    input  wire logic [15:0] i_magic,
    output t_result         o_res
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAYLOAD);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_hl, n_hl;
    logic [7:0]       r_flags, n_flags;
    logic [31:0]      r_ts, n_ts;
    logic [7:0]       r_pi, n_pi;
    logic [7:0]       r_fi, n_fi;
    logic [7:0]       r_sig, n_sig;
    logic [2:0]       r_status, n_status;

    logic [LEN_W-1:0] w_p_ext;
    logic [LEN_W-1:0] w_hl_ext;
    logic [LEN_W-1:0] w_len;
    logic [1:0]       w_sh;
    logic             w_content;
    logic [2:0]       w_st;
    logic [7:0]       w_b;

    always_comb begin
        w_b      = i_word.payload_byte;
        // start of frame clears the captures
        if (r_pos == '0) begin
            n_hl = '0; n_flags = '0; n_ts = '0; n_pi = '0; n_fi = '0; n_sig = '0;
            n_status = ST_OK;
        end else begin
            n_hl = r_hl; n_flags = r_flags; n_ts = r_ts; n_pi = r_pi; n_fi = r_fi;
            n_sig = r_sig; n_status = r_status;
        end
        n_pos     = r_pos;
        w_content = 1'b0;
        w_p_ext   = {1'b0, r_pos};
        w_hl_ext  = '0;
        w_sh      = '0;

        if (r_pos >= MAX_POS) begin
            if (n_status == ST_OK) begin
                n_status = ST_TOO_LONG;
            end
        end else begin
            if (r_pos == POS_W'(0) && w_b != i_magic[15:8] && n_status == ST_OK) begin
                n_status = ST_BAD_MAGIC;
            end
            if (r_pos == POS_W'(1) && w_b != i_magic[7:0] && n_status == ST_OK) begin
                n_status = ST_BAD_MAGIC;
            end
            if (r_pos == POS_W'(2)) begin
                n_hl = w_b;
            end
            if (r_pos == POS_W'(3)) begin
                n_flags = w_b;
            end
            if (r_pos == POS_W'(4)) begin
                n_sig = w_b;
            end
            if (r_pos >= POS_W'(2)) begin
                w_hl_ext = {2'b00, n_hl};
                if (w_p_ext + LEN_W'(6) == w_hl_ext) begin
                    n_pi = w_b;
                end
                if (w_p_ext + LEN_W'(5) == w_hl_ext) begin
                    n_fi = w_b;
                end
                // little-endian timestamp in the four bytes before content
                w_sh = r_pos[1:0] - n_hl[1:0];
                if (w_p_ext + LEN_W'(4) >= w_hl_ext && w_p_ext < w_hl_ext) begin
                    n_ts = n_ts | (32'(w_b) << {w_sh, 3'b000});
                end
            end
            if (n_status == ST_OK && r_pos >= MIN_PAYLOAD && n_hl >= MIN_HEADER
                && w_p_ext >= {2'b00, n_hl}) begin
                w_content = 1'b1;
            end
            n_pos = r_pos + POS_W'(1);
        end

        w_len = w_p_ext + LEN_W'(1);
        if (w_len < {1'b0, MIN_PAYLOAD}) begin
            w_st = ST_SHORT;
        end else if (n_status != ST_OK) begin
            w_st = n_status;
        end else if (n_hl < MIN_HEADER || {2'b00, n_hl} > w_len) begin
            w_st = ST_BAD_HDR;
        end else begin
            w_st = ST_OK;
        end

        if (i_word.frame_last) begin
            n_pos = '0;
        end

        o_res.has_result    = w_content || i_word.frame_last;
        o_res.word          = '0;
        o_res.word.content_byte  = w_content ? w_b : 8'd0;
        o_res.word.content_valid = w_content;
        if (i_word.frame_last) begin
            o_res.word.frame_end    = 1'b1;
            o_res.word.frame_status = w_st;
            if (w_st == ST_OK) begin
                o_res.word.frame_timestamp  = n_ts;
                o_res.word.is_multipart     = n_flags[FLAG_MULTI_BIT];
                o_res.word.part_num         = n_flags[FLAG_MULTI_BIT] ? n_pi : 8'd0;
                o_res.word.last_part_num    = n_flags[FLAG_MULTI_BIT] ? n_fi : 8'd0;
                o_res.word.is_signed        = n_flags[FLAG_SIGNED_BIT];
                o_res.word.signature_length = n_flags[FLAG_SIGNED_BIT] ? n_sig : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hl     <= '0;
            r_flags  <= '0;
            r_ts     <= '0;
            r_pi     <= '0;
            r_fi     <= '0;
            r_sig    <= '0;
            r_status <= ST_OK;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_hl     <= n_hl;
            r_flags  <= n_flags;
            r_ts     <= n_ts;
            r_pi     <= n_pi;
            r_fi     <= n_fi;
            r_sig    <= n_sig;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

[rtl/scfd_out_reg.sv]
// result register with stall handling for the deframer
// depends on scfd_pkg
`default_nettype none

module scfd_out_reg
    import scfd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_word i_word,
    input  wire logic      i_stall,
    output logic           o_valid,
    output t_out_word      o_word,
    output logic           o_free
);

    logic      r_valid, n_valid;
    t_out_word r_word;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[rtl/signed_chat_frame_deframer_unit.sv]
// Signed chat frame deframer, top level.
// Input channel: one payload word per item (a frame byte and its last-byte mark),
//   i_in_valid / o_in_stall; a word is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry a result word for each content
//   byte and for the last byte of each frame; other bytes give no result.
// The magic word register is written through i_cfg_wr_en / i_cfg_wr_data; the user must
//   write it only while the block is idle, which the block leaves to the user; it resets to 0xA455.
// Throughput: one byte per cycle while the result register is free or the byte gives no
//   result, set by the single decode pass between the input register and the result register.
// Path: a taken byte is held in the input register, decoded combinationally, and its result
//   is loaded into the result register, which drives the output channel.
// Reset (synchronous, active low) empties both registers, clears the frame
//   position and the captured header fields.
// When the receiver stalls, the pending result holds; bytes that give no result
//   still pass, the next byte with a result waits in the input register and
//   o_in_stall stays high until the result register frees.
// depends on scfd_pkg, scfd_core, scfd_out_reg and the assertion macro header
`default_nettype none

`include "signed_chat_frame_deframer_unit_defines.svh"

module signed_chat_frame_deframer_unit
    import scfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    logic     r_in_valid, n_in_valid;
    t_in_word r_in_word;
    logic     w_fire;
    logic     w_out_free;
    t_result  w_res;
    logic [15:0] r_magic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_wr_en) begin
            r_magic <= i_cfg_wr_data;
        end
    end

    // a byte with no result never waits on the output side
    assign w_fire     = r_in_valid && (!w_res.has_result || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;

    always_comb begin
        n_in_valid = (r_in_valid && !w_fire) || i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    scfd_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_word (r_in_word),
        .i_magic(r_magic),
        .o_res  (w_res)
    );

    scfd_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_fire && w_res.has_result),
        .i_word (w_res.word),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_word (o_out_word),
        .o_free (w_out_free)
    );

    `SCFD_ASSERT_SAME(a_result_has_purpose, o_out_valid,
        o_out_word.content_valid || o_out_word.frame_end,
        "result word carries neither content nor frame end")
    `SCFD_ASSERT_SAME(a_error_summary_zero,
        o_out_valid && o_out_word.frame_end && o_out_word.frame_status != ST_OK,
        o_out_word.frame_timestamp == 32'd0 && !o_out_word.is_multipart
            && !o_out_word.is_signed && o_out_word.signature_length == 8'd0,
        "summary fields not cleared on frame error")
    `SCFD_ASSERT_NEXT(a_out_drains,
        o_out_valid && !i_out_stall && !(w_fire && w_res.has_result),
        !o_out_valid,
        "result word not retired after it was taken")

endmodule

`default_nettype wire

[dv/signed_chat_frame_deframer_unit_test.sv]
// self-checking testbench for signed_chat_frame_deframer_unit: frames of bytes go in,
// a local deframer model predicts every result word and a checker compares them
// depends on scfd_pkg and the deframer rtl
`timescale 1ns / 100ps

module signed_chat_frame_deframer_unit_test;
    import scfd_pkg::*;

    localparam int unsigned MAX_LEN      = 256;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned HOLDOFF_LEN  = 300;
    localparam int unsigned TOTAL_ITEMS  = 2000;

    typedef logic [7:0] t_byte_q[$];
    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    signed_chat_frame_deframer_unit #(
        .MAX_PAYLOAD(MAX_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // deframer model state
    logic [15:0] magic_m;
    int unsigned pos_m;
    logic [7:0]  hdr_len_m;
    logic [7:0]  flags_m;
    logic [31:0] stamp_m;
    logic [7:0]  part_m;
    logic [7:0]  final_m;
    logic [7:0]  sig_len_m;
    logic [2:0]  status_m;

    t_out_word   expected_words[$];
    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    bit          steady_send = 0;
    int unsigned holdoff_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("signed_chat_frame_deframer_unit regression: fail");
        $finish;
    end

    function automatic void clear_capture();
        pos_m     = 0;
        hdr_len_m = '0;
        flags_m   = '0;
        stamp_m   = '0;
        part_m    = '0;
        final_m   = '0;
        sig_len_m = '0;
        status_m  = ST_OK;
    endfunction

    // returns 1 when the byte yields a result word
    function automatic bit deframe_byte(input t_in_word w, output t_out_word res);
        logic [7:0]  b;
        bit          content;
        int unsigned p;
        int unsigned len;
        logic [2:0]  st;
        b       = w.payload_byte;
        p       = pos_m;
        content = 1'b0;
        res     = '0;
        if (p == 0) clear_capture();
        if (p >= MAX_LEN) begin
            if (status_m == ST_OK) status_m = ST_TOO_LONG;
        end else begin
            if (p == 0 && b != magic_m[15:8] && status_m == ST_OK) status_m = ST_BAD_MAGIC;
            if (p == 1 && b != magic_m[7:0] && status_m == ST_OK) status_m = ST_BAD_MAGIC;
            if (p == 2) hdr_len_m = b;
            if (p == 3) flags_m = b;
            if (p == 4) sig_len_m = b;
            if (p >= 2) begin
                // captures follow offsets relative to the header end only
                if (p + 6 == hdr_len_m) part_m = b;
                if (p + 5 == hdr_len_m) final_m = b;
                if (p + 4 >= hdr_len_m && p < hdr_len_m)
                    stamp_m |= 32'(b) << (8 * ((p + 4 - hdr_len_m) % 4));
            end
            content = status_m == ST_OK && p >= MIN_HEADER && hdr_len_m >= MIN_HEADER
                      && p >= hdr_len_m;
            pos_m = p + 1;
        end
        if (!content && !w.frame_last) return 1'b0;
        if (content) begin
            res.content_byte  = b;
            res.content_valid = 1'b1;
        end
        if (w.frame_last) begin
            len = p + 1;
            if (len < MIN_PAYLOAD) st = ST_SHORT;
            else if (status_m != ST_OK) st = status_m;
            else if (hdr_len_m < MIN_HEADER || hdr_len_m > len) st = ST_BAD_HDR;
            else st = ST_OK;
            res.frame_end    = 1'b1;
            res.frame_status = st;
            if (st == ST_OK) begin
                res.frame_timestamp = stamp_m;
                res.is_multipart    = flags_m[FLAG_MULTI_BIT];
                res.part_num        = flags_m[FLAG_MULTI_BIT] ? part_m : 8'd0;
                res.last_part_num   = flags_m[FLAG_MULTI_BIT] ? final_m : 8'd0;
                res.is_signed       = flags_m[FLAG_SIGNED_BIT];
                res.signature_length = flags_m[FLAG_SIGNED_BIT] ? sig_len_m : 8'd0;
            end
            pos_m = 0;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] got);
        if (got !== exp) begin
            $error("%s: expected %0h, got %0h", name, exp, got);
            fail_count++;
        end
    endfunction

    // receiver: checks each accepted word, then picks the next stall value
    initial begin
        t_stall_mode stall_mode;
        int unsigned mode_left;
        int unsigned phase;
        t_out_word   exp;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        phase      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: %0h", o_out_word);
                    fail_count++;
                end else begin
                    exp = expected_words.pop_front();
                    check_field("content_byte", exp.content_byte, o_out_word.content_byte);
                    check_field("content_valid", exp.content_valid, o_out_word.content_valid);
                    check_field("frame_end", exp.frame_end, o_out_word.frame_end);
                    check_field("frame_status", exp.frame_status, o_out_word.frame_status);
                    check_field("frame_timestamp", exp.frame_timestamp,
                                o_out_word.frame_timestamp);
                    check_field("is_multipart", exp.is_multipart, o_out_word.is_multipart);
                    check_field("part_num", exp.part_num, o_out_word.part_num);
                    check_field("last_part_num", exp.last_part_num,
                                o_out_word.last_part_num);
                    check_field("is_signed", exp.is_signed, o_out_word.is_signed);
                    check_field("signature_length", exp.signature_length,
                                o_out_word.signature_length);
                end
            end
            phase++;
            if (holdoff_cycles > 0) begin
                i_out_stall <= 1'b1;
                holdoff_cycles--;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 80);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 5) == 0);
                    STALL_PERIODIC: i_out_stall <= (phase % 3 == 0);
                    default:        i_out_stall <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // one word in; waits for acceptance, then maybe opens a gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_word    w;
        t_out_word   res;
        int unsigned gap;
        w.payload_byte = b;
        w.frame_last   = last;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (deframe_byte(w, res)) expected_words.push_back(res);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = steady_send ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_frame(input t_byte_q fr);
        int i;
        for (i = 0; i < fr.size(); i++) send_byte(fr[i], i == fr.size() - 1);
    endtask

    // random bytes with magic, header length and flags at their offsets
    function automatic t_byte_q make_frame(input int unsigned len, input logic [7:0] hl,
                                           input logic [7:0] flags);
        t_byte_q q;
        int unsigned i;
        for (i = 0; i < len; i++) q.push_back(8'($urandom));
        if (len > 0) q[0] = magic_m[15:8];
        if (len > 1) q[1] = magic_m[7:0];
        if (len > 2) q[2] = hl;
        if (len > 3) q[3] = flags;
        return q;
    endfunction

    // stop sending and let every expected word and any in-flight byte drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_magic(input logic [15:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        magic_m = value;
    endtask

    task automatic test_short_frames();
        send_frame(make_frame(1, 8'd8, 8'h00));
        send_frame(make_frame(7, 8'd8, 8'h03));
    endtask

    task automatic test_bad_magic();
        t_byte_q fr;
        fr = make_frame(12, 8'd8, 8'h00);
        fr[0] = ~fr[0];
        send_frame(fr);
        fr = make_frame(12, 8'd8, 8'h03);
        fr[1] = fr[1] ^ 8'h80;
        send_frame(fr);
    endtask

    task automatic test_header_length();
        send_frame(make_frame(12, 8'd7, 8'h03));
        send_frame(make_frame(10, 8'd0, 8'h00));
        send_frame(make_frame(12, 8'd20, 8'h00));  // header runs past the frame end
        send_frame(make_frame(8, 8'd8, 8'h03));    // exact fit, no content
    endtask

    task automatic test_flags_and_content();
        t_byte_q fr;
        fr = make_frame(13, 8'd10, 8'h03);
        fr[10] = 8'h00;
        fr[11] = 8'hFF;
        send_frame(fr);
        // part number lands on the header length byte itself
        send_frame(make_frame(10, 8'd8, 8'h01));
        send_frame(make_frame(10, 8'd8, 8'hFC));
    endtask

    task automatic test_too_long();
        t_byte_q fr;
        send_frame(make_frame(MAX_LEN, 8'd255, 8'hFF));
        send_frame(make_frame(MAX_LEN + 14, 8'd8, 8'h02));
        fr = make_frame(MAX_LEN + 4, 8'd8, 8'h00);
        fr[0] = ~fr[0];  // magic error is kept over length error
        send_frame(fr);
    endtask

    task automatic test_magic_config();
        t_byte_q fr;
        write_magic(16'h0000);
        send_frame(make_frame(12, 8'd8, 8'h01));
        write_magic(16'hFFFF);
        send_frame(make_frame(12, 8'd9, 8'h02));
        fr = make_frame(12, 8'd8, 8'h00);
        fr[0] = MAGIC_RESET[15:8];
        fr[1] = MAGIC_RESET[7:0];
        send_frame(fr);
        write_magic(16'($urandom));
        send_frame(make_frame(14, 8'd8, 8'h03));
        write_magic(MAGIC_RESET);
    endtask

    // receiver holds off while the sender keeps going, so the input backs up
    task automatic test_receiver_holdoff();
        wait_idle();
        holdoff_cycles = HOLDOFF_LEN;
        steady_send    = 1'b1;
        send_frame(make_frame(120, 8'd8, 8'h03));
        steady_send = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (3) send_frame(make_frame($urandom_range(8, 30), 8'($urandom_range(8, 12)),
                                         8'($urandom)));
        wait_idle();
        repeat (3) send_frame(make_frame($urandom_range(8, 30), 8'($urandom_range(8, 12)),
                                         8'($urandom)));
    endtask

    // random frames until the whole run has sent about TOTAL_ITEMS bytes
    task automatic test_random_frames();
        t_byte_q     fr;
        int unsigned kind;
        int unsigned len;
        int unsigned stop_at;
        int unsigned next_cfg;
        int unsigned idx;
        logic [7:0]  hl;
        stop_at  = TOTAL_ITEMS;
        next_cfg = bytes_sent + 400;
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= next_cfg) begin
                case ($urandom_range(0, 3))
                    0:       write_magic(16'h0000);
                    1:       write_magic(16'hFFFF);
                    2:       write_magic(MAGIC_RESET);
                    default: write_magic(16'($urandom));
                endcase
                next_cfg += 400;
            end
            steady_send = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                hl  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 200))
                                                  : 8'($urandom_range(8, 24));
                len = hl + $urandom_range(0, 40);
                if (len > MAX_LEN) len = MAX_LEN;
                fr = make_frame(len, hl, 8'($urandom));
            end else if (kind < 72) begin
                fr = make_frame($urandom_range(MAX_LEN + 1, MAX_LEN + 12),
                                8'($urandom_range(8, 16)), 8'($urandom));
            end else if (kind < 82) begin
                fr  = make_frame($urandom_range(8, 40), 8'($urandom_range(8, 12)), 8'($urandom));
                idx = $urandom_range(0, 1);
                fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(0, 7));
            end else if (kind < 92) begin
                fr = make_frame($urandom_range(8, 40), 8'($urandom), 8'($urandom));
            end else begin
                fr.delete();
                repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom));
            end
            send_frame(fr);
        end
        steady_send = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_word     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        magic_m = MAGIC_RESET;
        clear_capture();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_bad_magic();
        test_header_length();
        test_flags_and_content();
        test_too_long();
        test_magic_config();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_frames();
        wait_idle();

        if (fail_count == 0) begin
            $display("signed_chat_frame_deframer_unit regression: pass");
        end else begin
            $display("signed_chat_frame_deframer_unit regression: fail");
        end
        $finish;
    end

endmodule
